// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the checker file xcnl_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define XCNL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xcnl assertion failed");

// next-cycle implication, disabled while in reset
`define XCNL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xcnl assertion failed");

`endif

// ===== hw/rtl/xcnl_pkg.sv =====
`default_nettype none

package xcnl_pkg;

  localparam int LIST_DEPTH = 8;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(LIST_DEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_TARGET_HIGH   = 2'd0,
    REG_TARGET_MIDDLE = 2'd1,
    REG_TARGET_LOW    = 2'd2,
    REG_ADDR_FAMILY   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] node_id_high;
    logic [63:0] node_id_middle;
    logic [63:0] node_id_low;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] peer_port;
    logic [2:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  entry_total;
    logic        inserted;
    logic [3:0]  rank;
    logic [31:0] out_id_high;
    logic [63:0] out_id_middle;
    logic [63:0] out_id_low;
    logic [63:0] out_address_high;
    logic [63:0] out_address_low;
    logic [15:0] out_port;
  } out_item_t;

  // one held peer
  typedef struct packed {
    logic [159:0] id;
    logic [63:0]  addr_high;
    logic [63:0]  addr_low;
    logic [15:0]  port;
  } entry_t;

  // passed from cell to cell down the row
  typedef struct packed {
    logic found;   // an earlier cell already claimed the offer's rank
    logic insert;  // and that claim places the offer (not a duplicate)
  } link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xor_closest_node_list_unit.sv =====
`default_nettype none

// sorted peer list: holds up to eight peers (160-bit id, address, port) in ascending
// xor distance from a configured target id. opcode clear empties the list, offer
// inserts a peer at its rank (duplicates and peers farther than a full list are
// refused, the farthest entry drops off a full list), read returns the entry at
// read_index or zeros past the held count. every transfer gives exactly one result.
// all cells compare their entry with the offer in parallel and the claim ripples down the
// row of cells, so a new item can be taken every cycle unless a waiting result is stalled.
// in ipv4 mode only the low 32 address bits are kept. configuration writes must only be
// made while no result is outstanding; the block does not enforce this.

module xor_closest_node_list_unit
  import xcnl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // configuration registers
  logic [31:0] target_high_r;
  logic [63:0] target_middle_r;
  logic [63:0] target_low_r;
  logic        family_r;
  logic [159:0] target;

  // list occupancy
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // result register
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_r;
  out_item_t out_nxt;

  logic   accept;
  logic   load_en;
  entry_t offer;
  logic [LIST_DEPTH-1:0] occ;
  logic [LIST_DEPTH-1:0] hit;
  link_t  links [LIST_DEPTH+1];
  entry_t cell_entry [LIST_DEPTH];
  logic   placed;
  logic [CNT_W-1:0] rank;
  logic   rd_hit;

  assign target = {target_high_r, target_middle_r, target_low_r};

  // a transfer is taken unless a result is waiting and the far side stalls
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign load_en  = accept && (in_data.opcode == OP_OFFER);

  // offered entry, address trimmed in ipv4 mode
  always_comb begin
    offer.id   = {in_data.node_id_high, in_data.node_id_middle, in_data.node_id_low};
    offer.port = in_data.peer_port;
    if (family_r) begin
      offer.addr_high = in_data.address_high;
      offer.addr_low  = in_data.address_low;
    end else begin
      offer.addr_high = '0;
      offer.addr_low  = {32'd0, in_data.address_low[31:0]};
    end
  end

  // slots below the count hold live peers
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      occ[i] = CNT_W'(i) < count_r;
    end
  end

  // row of cells, the rank claim ripples from slot 0 downwards
  assign links[0] = '0;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    entry_t prev;
    if (g == 0) begin : g_head
      assign prev = offer;
    end else begin : g_body
      assign prev = cell_entry[g-1];
    end
    xcnl_cell u_cell (
      .clk        (clk),
      .occupied   (occ[g]),
      .target     (target),
      .load_en    (load_en),
      .offer      (offer),
      .prev_entry (prev),
      .link_in    (links[g]),
      .link_out   (links[g+1]),
      .hit        (hit[g]),
      .entry      (cell_entry[g])
    );
  end

  // offer is placed when some cell claimed it for insertion
  assign placed = links[LIST_DEPTH].insert;

  always_comb begin
    rank = CNT_W'(LIST_DEPTH);
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (hit[i]) begin
        rank = CNT_W'(i);
      end
    end
  end

  assign rd_hit = {1'b0, in_data.read_index} < count_r;

  // next count
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      unique case (in_data.opcode)
        OP_CLEAR: count_nxt = '0;
        OP_OFFER: begin
          if (placed && (count_r < CNT_W'(LIST_DEPTH))) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        default: count_nxt = count_r;
      endcase
    end
  end

  // result built from the transfer and the list as it stood
  always_comb begin
    out_nxt             = '0;
    out_nxt.entry_total = count_nxt;
    out_nxt.rank        = CNT_W'(LIST_DEPTH);
    unique case (in_data.opcode)
      OP_OFFER: begin
        out_nxt.inserted = placed;
        out_nxt.rank     = placed ? rank : CNT_W'(LIST_DEPTH);
      end
      OP_READ: begin
        if (rd_hit) begin
          out_nxt.out_id_high      = cell_entry[in_data.read_index].id[159:128];
          out_nxt.out_id_middle    = cell_entry[in_data.read_index].id[127:64];
          out_nxt.out_id_low       = cell_entry[in_data.read_index].id[63:0];
          out_nxt.out_address_high = cell_entry[in_data.read_index].addr_high;
          out_nxt.out_address_low  = cell_entry[in_data.read_index].addr_low;
          out_nxt.out_port         = cell_entry[in_data.read_index].port;
        end
      end
      default: out_nxt.inserted = 1'b0;
    endcase
  end

  // result stays until the far side takes it
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_high_r   <= '0;
      target_middle_r <= '0;
      target_low_r    <= '0;
      family_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TARGET_HIGH:   target_high_r   <= cfg_wdata[31:0];
        REG_TARGET_MIDDLE: target_middle_r <= cfg_wdata;
        REG_TARGET_LOW:    target_low_r    <= cfg_wdata;
        REG_ADDR_FAMILY:   family_r        <= cfg_wdata[0];
        default:           family_r        <= family_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/xcnl_cell.sv =====
`default_nettype none

module xcnl_cell
  import xcnl_pkg::*;
(
  input  logic         clk,
  input  logic         occupied,
  input  logic [159:0] target,
  input  logic         load_en,
  input  entry_t       offer,
  input  entry_t       prev_entry,
  input  link_t        link_in,
  output link_t        link_out,
  output logic         hit,
  output entry_t       entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   dup;
  logic   closer;
  logic   stop;
  logic   take_new;
  logic   take_prev;

  // xor distance compare against the held id
  assign dup    = occupied && (entry_r.id == offer.id);
  assign closer = occupied && ((offer.id ^ target) < (entry_r.id ^ target));
  assign stop   = !occupied || dup || closer;

  assign take_new  = !link_in.found && stop && !dup;
  assign take_prev = link_in.found && link_in.insert;

  assign link_out.found  = link_in.found || stop;
  assign link_out.insert = link_in.found ? link_in.insert : (stop && !dup);
  assign hit             = take_new;

  always_comb begin
    entry_nxt = entry_r;
    if (load_en && take_new) begin
      entry_nxt = offer;
    end else if (load_en && take_prev) begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== hw/rtl/xcnl_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module xcnl_checker
  import xcnl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held result must not vanish
  `XCNL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // back-pressure only comes from a waiting result
  `XCNL_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // a transfer always produces a result next cycle
  `XCNL_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && !in_stall, out_valid)

  // rank agrees with the inserted flag
  `XCNL_ASSERT_IMPL(a_rank_flag, clk, rst_n, out_valid, out_data.inserted == (out_data.rank < 4'(LIST_DEPTH)))

  // never more entries than slots
  `XCNL_ASSERT_IMPL(a_total_max, clk, rst_n, out_valid, out_data.entry_total <= 4'(LIST_DEPTH))

endmodule

bind xor_closest_node_list_unit xcnl_checker u_xcnl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
